/* rtl/direct_mapped_writeback_cache_tags_core_defines.svh */
// Assertion macros for the cache tag controller.
// Used by direct_mapped_writeback_cache_tags_core; needs clk_i and rst_ni in scope.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_CORE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_TAGS_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dmc_pkg.sv */
// Package of the direct-mapped write-back cache tag controller.
// Holds geometry constants, stream widths and the controller state type; no dependencies.
package dmc_pkg;

  localparam int unsigned NumLines   = 128;
  localparam int unsigned BlockBytes = 32;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned CountW     = 32;

  localparam int unsigned OffW   = $clog2(BlockBytes);
  localparam int unsigned IdxW   = $clog2(NumLines);
  localparam int unsigned BlockW = AddrW - OffW;
  localparam int unsigned TagW   = BlockW - IdxW;

  localparam int unsigned InRawW  = AddrW + 1;
  localparam int unsigned InDataW = ((InRawW + 7) / 8) * 8;

  localparam int unsigned OutRawW  = OffW + BlockW + IdxW + TagW + 4 + TagW + 3 * CountW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } dmc_state_e;

endpackage

/* rtl/direct_mapped_writeback_cache_tags_core.sv */
// Top level of the direct-mapped write-back write-allocate cache tag controller.
// Depends on dmc_pkg and direct_mapped_writeback_cache_tags_core_defines.svh.
//
//   Channel   Direction  Word
//   s_axis    in         one memory reference: address, is_write
//   m_axis    out        lookup result: address split, hit/miss flags, totals
//
// Each reference reads the tag memory into rdata_q when taken, then compares and writes back.
// A new word is taken only from idle, so the next reference waits until this lookup completes.
// Reset clears the valid bits and totals at once; no clearing pass is needed.
// A stalled result sits in the output register and holds the lookup until it drains.
`include "direct_mapped_writeback_cache_tags_core_defines.svh"

module direct_mapped_writeback_cache_tags_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: address, is_write, zero fill.
  input  logic [dmc_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: byte_offset, block_number, line_index, ref_tag, miss, fill_read,
  // writeback, replacement, evicted_tag, hit_total, miss_total, writeback_total, zero fill.
  output logic [dmc_pkg::OutDataW-1:0]  m_axis_tdata
);

  import dmc_pkg::*;

  dmc_state_e state_q, state_d;

  logic [AddrW-1:0]    addr_q;
  logic                wr_q;
  logic [TagW:0]       tag_mem [NumLines];
  logic [TagW:0]       rdata_q;
  logic [NumLines-1:0] valid_q;

  logic [CountW-1:0] hits_q, hits_d;
  logic [CountW-1:0] misses_q, misses_d;
  logic [CountW-1:0] wbs_q, wbs_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  logic accept;
  logic complete;

  logic [BlockW-1:0] in_block;
  logic [IdxW-1:0]   in_idx;

  logic [OffW-1:0]   ref_off;
  logic [BlockW-1:0] ref_block;
  logic [IdxW-1:0]   ref_idx;
  logic [TagW-1:0]   ref_tag;
  logic [TagW-1:0]   rd_tag;
  logic              rd_dirty;
  logic              line_vld;
  logic              hit;
  logic              repl;
  logic              wb;
  logic [TagW-1:0]   evicted;
  logic              new_dirty;

  assign in_block = s_axis_tdata[AddrW-1:OffW];
  assign in_idx   = in_block[IdxW-1:0];

  assign ref_off   = addr_q[OffW-1:0];
  assign ref_block = addr_q[AddrW-1:OffW];
  assign ref_idx   = ref_block[IdxW-1:0];
  assign ref_tag   = ref_block[BlockW-1:IdxW];

  assign rd_tag    = rdata_q[TagW-1:0];
  assign rd_dirty  = rdata_q[TagW];
  assign line_vld  = valid_q[ref_idx];
  assign hit       = line_vld && (rd_tag == ref_tag);
  assign repl      = line_vld && !hit;
  assign wb        = repl && rd_dirty;
  assign evicted   = repl ? rd_tag : '0;
  assign new_dirty = hit ? (rd_dirty | wr_q) : wr_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    complete      = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_LOOKUP: complete = !out_valid_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        complete      = 1'b0;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    wbs_d    = wbs_q;
    if (hit) begin
      if (hits_q != '1) hits_d = hits_q + 1'b1;
    end else begin
      if (misses_q != '1) misses_d = misses_q + 1'b1;
      if (wb && (wbs_q != '1)) wbs_d = wbs_q + 1'b1;
    end
  end

  always_comb begin
    out_data_d = {{(OutDataW - OutRawW){1'b0}}, wbs_d, misses_d, hits_d, evicted,
                  repl, wb, !hit, !hit, ref_tag, ref_idx, ref_block, ref_off};
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (complete) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (complete) begin
      tag_mem[ref_idx] <= {new_dirty, ref_tag};
    end
    if (accept) begin
      rdata_q <= tag_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= s_axis_tdata[AddrW-1:0];
      wr_q   <= s_axis_tdata[AddrW];
    end
    if (complete) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      wbs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (complete) begin
        valid_q[ref_idx] <= 1'b1;
        hits_q           <= hits_d;
        misses_q         <= misses_d;
        wbs_q            <= wbs_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `DMC_ASSERT_NEXT(a_accept_to_lookup, accept, state_q == ST_LOOKUP,
                   "accepted word did not start a lookup")
  `DMC_ASSERT_NEXT(a_line_valid_after, complete, valid_q[ref_idx] && out_valid_q,
                   "completed lookup left the line invalid or no result")
  `DMC_ASSERT_SAME(a_wb_needs_repl, complete && wb, repl && !hit,
                   "writeback without replacement of a valid line")
  `DMC_ASSERT_SAME(a_evicted_zero, complete && !repl, evicted == '0,
                   "evicted tag nonzero without replacement")

endmodule
